// ----- rtl/mdf_pkg.sv -----
`default_nettype none

package mdf_pkg;

  // Framing modes; the unused code behaves as pass-through.
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_LENGTH = 2'd1;
  localparam logic [1:0] MODE_DELIM  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd1;

  localparam int unsigned LEN_W        = 31;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 31'h7FFF_FFFF;
  localparam int unsigned HEADER_BYTES_DEF = 4;

  // Delimiter bytes.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Results per input byte and rows in the result queue.
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_CNT_W   = 3;
  localparam int unsigned FIFO_ROWS   = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       message_end;
    logic       length_error;
  } res_t;

  // All results caused by one input byte, in delivery order.
  typedef struct packed {
    res_t [MAX_RESULTS-1:0]  items;
    logic [RES_CNT_W-1:0]    n;
  } row_t;

  // Byte of the CR LF CR LF delimiter at a given position.
  function automatic logic [7:0] delim_byte(input logic [1:0] pos);
    delim_byte = pos[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mdf_ifs.sv -----
`default_nettype none

// Input byte channel.
interface mdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface mdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       message_end;
  logic       length_error;

  modport source (output valid, output out_byte, output byte_valid,
                  output message_end, output length_error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input message_end, input length_error, output ready);
endinterface

// Configuration write channel.
interface mdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/message_deframer_unit.sv -----
// Channel   Direction  Payload
// in_ch     sink       in_byte[7:0]
// out_ch    source     out_byte[7:0], byte_valid, message_end, length_error
// cfg_ch    sink       index[1:0], data[30:0] (0 framing_mode, 1 max_length)
//
// One byte is accepted per cycle while in_ch.ready is high; it is processed the cycle
// after its transfer and its results are queued as one row in a four-row result queue.
// Results leave one per cycle while out_ch.ready is high, after the input register
// and the queue; a byte releasing several held bytes gives a result for each of them.
// in_ch.ready drops only when the result queue cannot take two more rows.
// Synchronous active-low reset empties the queue and clears all framing state.
`default_nettype none

module message_deframer_unit #(
  parameter int unsigned HEADER_BYTES = mdf_pkg::HEADER_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mdf_in_if.sink     in_ch,
  mdf_out_if.source  out_ch,
  mdf_cfg_if.sink    cfg_ch
);
  import mdf_pkg::*;

  localparam int unsigned HDR_CNT_W = $clog2(HEADER_BYTES + 1);
  localparam int unsigned PTR_W     = $clog2(FIFO_ROWS);
  localparam int unsigned FCNT_W    = $clog2(FIFO_ROWS + 1);
  localparam int unsigned SUB_W     = $clog2(MAX_RESULTS);

  // Configuration registers.
  logic [1:0]           mode_r;
  logic [LEN_W-1:0]     max_len_r;

  // Framing state.
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]          hdr_val_r, hdr_val_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic                 in_pay_r, in_pay_nxt;
  logic [1:0]           dm_r, dm_nxt;

  // Input register.
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;

  // Result queue.
  row_t                 rows_r [FIFO_ROWS];
  logic [PTR_W-1:0]     rd_ptr_r, wr_ptr_r;
  logic [FCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUB_W-1:0]     sub_r;

  row_t                 row_new;
  row_t                 head;
  res_t                 head_item;
  logic                 in_xfer, out_xfer, push, pop;
  logic [31:0]          hv_add;
  logic [HDR_CNT_W-1:0] cnt_inc;
  logic [LEN_W-1:0]     rem_dec;

  // Room for the row of the byte in the input register plus one more.
  assign in_ch.ready  = ({1'b0, cnt_r} + {{FCNT_W{1'b0}}, s1_valid_r})
                        <= (FCNT_W + 1)'(FIFO_ROWS - 1);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PASS;
      max_len_r <= MAX_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FRAMING_MODE: mode_r    <= cfg_ch.data[1:0];
        CFG_MAX_LENGTH:   max_len_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
    if (in_xfer) begin
      s1_byte_r <= in_ch.in_byte;
    end
  end

  // Header byte merged into the assembled length.
  always_comb begin
    hv_add = hdr_val_r;
    for (int i = 0; i < 4; i++) begin
      if (32'(hdr_cnt_r) == 32'(i)) begin
        hv_add[8*i +: 8] = hdr_val_r[8*i +: 8] | s1_byte_r;
      end
    end
  end

  assign cnt_inc = hdr_cnt_r + 1'b1;
  assign rem_dec = rem_r - 1'b1;

  // Framing logic for the byte in the input register.
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    hdr_val_nxt = hdr_val_r;
    rem_nxt     = rem_r;
    in_pay_nxt  = in_pay_r;
    dm_nxt      = dm_r;
    row_new     = '0;

    case (mode_r)
      MODE_LENGTH: begin
        if (in_pay_r) begin
          row_new.items[0].out_byte   = s1_byte_r;
          row_new.items[0].byte_valid = 1'b1;
          row_new.n                   = RES_CNT_W'(1);
          rem_nxt                     = rem_dec;
          if (rem_dec == '0) begin
            in_pay_nxt                   = 1'b0;
            row_new.items[1].message_end = 1'b1;
            row_new.n                    = RES_CNT_W'(2);
          end
        end else if (cnt_inc < HDR_CNT_W'(HEADER_BYTES)) begin
          hdr_cnt_nxt = cnt_inc;
          hdr_val_nxt = hv_add;
        end else begin
          hdr_cnt_nxt = '0;
          hdr_val_nxt = '0;
          if (hv_add > {1'b0, max_len_r}) begin
            row_new.items[0].length_error = 1'b1;
            row_new.n                     = RES_CNT_W'(1);
          end else if (hv_add == '0) begin
            row_new.items[0].message_end = 1'b1;
            row_new.n                    = RES_CNT_W'(1);
          end else begin
            rem_nxt    = hv_add[LEN_W-1:0];
            in_pay_nxt = 1'b1;
          end
        end
      end
      MODE_DELIM: begin
        if (s1_byte_r == delim_byte(dm_r)) begin
          if (dm_r == 2'd3) begin
            row_new.items[0].message_end = 1'b1;
            row_new.n                    = RES_CNT_W'(1);
            dm_nxt                       = '0;
          end else begin
            dm_nxt = dm_r + 1'b1;
          end
        end else begin
          // Held delimiter bytes are released; a CR may start a new match.
          for (int i = 0; i < 3; i++) begin
            if (32'(dm_r) > 32'(i)) begin
              row_new.items[i].out_byte   = delim_byte(2'(i));
              row_new.items[i].byte_valid = 1'b1;
            end
          end
          if (s1_byte_r == CHAR_CR) begin
            row_new.n = RES_CNT_W'(dm_r);
            dm_nxt    = 2'd1;
          end else begin
            row_new.items[dm_r].out_byte   = s1_byte_r;
            row_new.items[dm_r].byte_valid = 1'b1;
            row_new.n                      = RES_CNT_W'(dm_r) + 1'b1;
            dm_nxt                         = '0;
          end
        end
      end
      default: begin
        row_new.items[0].out_byte   = s1_byte_r;
        row_new.items[0].byte_valid = 1'b1;
        row_new.n                   = RES_CNT_W'(1);
      end
    endcase
  end

  // Framing state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= '0;
      hdr_val_r <= '0;
      rem_r     <= '0;
      in_pay_r  <= 1'b0;
      dm_r      <= '0;
    end else if (s1_valid_r) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      hdr_val_r <= hdr_val_nxt;
      rem_r     <= rem_nxt;
      in_pay_r  <= in_pay_nxt;
      dm_r      <= dm_nxt;
    end
  end

  // Result queue output side.
  assign head      = rows_r[rd_ptr_r];
  assign head_item = head.items[sub_r];
  assign push      = s1_valid_r && (row_new.n != '0);
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign pop       = out_xfer && ((RES_CNT_W'(sub_r) + 1'b1) == head.n);

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_byte     = head_item.out_byte;
  assign out_ch.byte_valid   = head_item.byte_valid;
  assign out_ch.message_end  = head_item.message_end;
  assign out_ch.length_error = head_item.length_error;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Queue pointers and row storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        sub_r    <= '0;
      end else if (out_xfer) begin
        sub_r <= sub_r + 1'b1;
      end
    end
    if (push) begin
      rows_r[wr_ptr_r] <= row_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mdf_checker.sv -----
`default_nettype none

module mdf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       message_end,
  input wire logic       length_error
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(message_end) && $stable(length_error))
    else $error("result changed while stalled");

  // Every result is exactly one of byte, end marker or error.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({byte_valid, message_end, length_error}))
    else $error("result is not exactly one kind");

  // Marker and error results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> out_byte == 8'h00)
    else $error("marker result carries a byte");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

endmodule

bind message_deframer_unit mdf_checker u_mdf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .byte_valid   (out_ch.byte_valid),
  .message_end  (out_ch.message_end),
  .length_error (out_ch.length_error)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mdf_pkg::*;

  // The fourth mode code has no name in the package; it must act as pass-through.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned HB = HEADER_BYTES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [3:0][7:0] TERM_SEQ = {CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR};

  logic clk;
  logic rst_n;

  mdf_in_if  in_ch ();
  mdf_out_if out_ch ();
  mdf_cfg_if cfg_ch ();

  message_deframer_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor copy of the configuration and the framing state.
  logic [1:0]  p_mode;
  logic [30:0] p_max;
  int unsigned hdr_cnt;
  logic [31:0] hdr_val;
  logic [30:0] remaining;
  bit          in_payload;
  int          held_cnt;

  res_t        pending_results[$];
  logic [7:0]  tx_bytes[$];
  int          mismatch_count;
  int          bytes_sent;
  int          cycle_count;
  bit          gaps_en;
  bit          stall_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void expect_result(logic [7:0] byt, bit bv, bit me, bit le);
    res_t r;
    r.out_byte     = bv ? byt : 8'h00;
    r.byte_valid   = bv;
    r.message_end  = me;
    r.length_error = le;
    pending_results.push_back(r);
  endfunction

  // Work out the results that one accepted byte causes and advance the state.
  function automatic void predict_deframe(logic [7:0] b);
    logic [7:0]  held [0:3];
    logic [31:0] len;
    int          m;
    int          total;
    int          keep;
    int          k;
    int          i;
    bit          same;
    case (p_mode)
      MODE_LENGTH: begin
        if (in_payload) begin
          expect_result(b, 1'b1, 1'b0, 1'b0);
          remaining = remaining - 31'd1;
          if (remaining == 31'd0) begin
            in_payload = 1'b0;
            expect_result(8'h00, 1'b0, 1'b1, 1'b0);
          end
        end else begin
          // Bytes past the fourth are consumed but carry no length bits.
          if (hdr_cnt < 4) hdr_val = hdr_val | (32'(b) << (8 * hdr_cnt));
          hdr_cnt++;
          if (hdr_cnt >= HB) begin
            len     = hdr_val;
            hdr_cnt = 0;
            hdr_val = 32'd0;
            if (len > {1'b0, p_max}) begin
              expect_result(8'h00, 1'b0, 1'b0, 1'b1);
            end else if (len == 32'd0) begin
              expect_result(8'h00, 1'b0, 1'b1, 1'b0);
            end else begin
              remaining  = len[30:0];
              in_payload = 1'b1;
            end
          end
        end
      end
      MODE_DELIM: begin
        m = held_cnt;
        if (b == TERM_SEQ[m]) begin
          m++;
          if (m == 4) begin
            held_cnt = 0;
            expect_result(8'h00, 1'b0, 1'b1, 1'b0);
          end else begin
            held_cnt = m;
          end
        end else begin
          // Release everything but the longest tail that still starts the delimiter.
          for (i = 0; i < m; i++) held[i] = TERM_SEQ[i];
          held[m] = b;
          total   = m + 1;
          keep    = 0;
          for (k = (total < 3) ? total : 3; k > 0 && keep == 0; k--) begin
            same = 1'b1;
            for (i = 0; i < k; i++) begin
              if (held[total - k + i] != TERM_SEQ[i]) same = 1'b0;
            end
            if (same) keep = k;
          end
          for (i = 0; i < total - keep; i++) expect_result(held[i], 1'b1, 1'b0, 1'b0);
          held_cnt = keep;
        end
      end
      default: begin
        expect_result(b, 1'b1, 1'b0, 1'b0);
      end
    endcase
  endfunction

  // Offer one byte, with an occasional idle burst before it, and predict on transfer.
  task automatic send_byte(input logic [7:0] b);
    if (gaps_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_deframe(b);
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
    tx_bytes.delete();
  endtask

  // Drop valid, wait for every expected result, then let in-flight bytes settle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the mode and optionally the length limit; valid stays high between writes.
  task automatic program_regs(input logic [1:0] mode, input bit set_max,
                              input logic [30:0] max_val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_FRAMING_MODE;
    cfg_ch.data  <= {29'd0, mode};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    p_mode = mode;
    if (set_max) begin
      cfg_ch.index <= CFG_MAX_LENGTH;
      cfg_ch.data  <= max_val;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      p_max = max_val;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Build a byte stream of about target bytes that suits the given mode.
  task automatic build_phase(input logic [1:0] mode, input int target);
    logic [31:0] hv;
    int          choice;
    int          len;
    int          i;
    int          r;
    case (mode)
      MODE_LENGTH: begin
        // Close what an earlier length phase left open; a 0xFF top byte forces an error.
        if (hdr_cnt != 0) begin
          repeat (HB - hdr_cnt) tx_bytes.push_back(8'hFF);
        end else if (in_payload) begin
          repeat (remaining) tx_bytes.push_back(8'($urandom));
        end
        while (tx_bytes.size() < target) begin
          choice = $urandom_range(0, 9);
          if (choice == 0) begin
            hv = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                      : ({1'b0, p_max} + 32'd1);
            for (i = 0; i < HB; i++) tx_bytes.push_back(hv[8 * (i % 4) +: 8]);
          end else if (choice == 1 && p_max <= 31'd20) begin
            repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
          end else begin
            len = (choice == 2 && p_max <= 31'd20) ? int'(p_max) : $urandom_range(0, 12);
            hv  = 32'(len);
            for (i = 0; i < HB; i++) tx_bytes.push_back(hv[8 * (i % 4) +: 8]);
            repeat (len) tx_bytes.push_back(8'($urandom));
          end
        end
      end
      MODE_DELIM: begin
        while (tx_bytes.size() < target) begin
          repeat ($urandom_range(0, 10)) begin
            r = $urandom_range(0, 5);
            tx_bytes.push_back(r == 0 ? CHAR_CR : (r == 1 ? CHAR_LF : 8'($urandom)));
          end
          if ($urandom_range(0, 4) != 0) begin
            for (i = 0; i < 4; i++) tx_bytes.push_back(TERM_SEQ[i]);
          end else begin
            // A delimiter that breaks off part way.
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) tx_bytes.push_back(TERM_SEQ[i]);
            tx_bytes.push_back(8'($urandom));
          end
        end
      end
      default: begin
        repeat (target) begin
          r = $urandom_range(0, 7);
          tx_bytes.push_back(r == 0 ? 8'h00 : (r == 1 ? 8'hFF : 8'($urandom)));
        end
      end
    endcase
    // Sometimes end the phase inside a frame so the next mode change interrupts it.
    if ($urandom_range(0, 2) == 0 && tx_bytes.size() > 1) begin
      repeat ($urandom_range(1, (tx_bytes.size() - 1 < 5) ? tx_bytes.size() - 1 : 5))
        void'(tx_bytes.pop_back());
    end
  endtask

  task automatic test_reset_defaults();
    tx_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    send_stream();
  endtask

  task automatic test_spare_mode();
    settle();
    program_regs(MODE_SPARE, 1'b0, 31'd0);
    tx_bytes = '{CHAR_CR, CHAR_LF};
    send_stream();
  endtask

  // Zero length, a one-byte payload and an all-ones header that must raise a length error.
  task automatic test_length_directed();
    settle();
    program_regs(MODE_LENGTH, 1'b1, MAX_LENGTH_RST);
    tx_bytes = '{8'h00, 8'h00, 8'h00, 8'h00,
                 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_stream();
  endtask

  // A full delimiter, then a partial match released by a mismatch.
  task automatic test_delimiter_directed();
    settle();
    program_regs(MODE_DELIM, 1'b0, 31'd0);
    tx_bytes = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR, 8'h41};
    send_stream();
  endtask

  task automatic test_random_phases();
    logic [1:0]  mode;
    logic [30:0] max_val;
    bit          set_max;
    int          sel;
    gaps_en  = 1'b1;
    stall_en = 1'b1;
    while (bytes_sent < 290) begin
      settle();
      sel  = $urandom_range(0, 9);
      mode = (sel < 4) ? MODE_LENGTH : (sel < 7) ? MODE_DELIM :
             (sel < 9) ? MODE_PASS : MODE_SPARE;
      set_max = 1'b1;
      case ($urandom_range(0, 4))
        0:       max_val = 31'd0;
        1:       max_val = 31'($urandom_range(1, 20));
        2:       max_val = MAX_LENGTH_RST;
        3:       max_val = 31'($urandom);
        default: begin
          max_val = p_max;
          set_max = 1'b0;
        end
      endcase
      program_regs(mode, set_max, max_val);
      build_phase(mode, $urandom_range(15, 35));
      send_stream();
    end
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_full_rate();
    gaps_en  = 1'b0;
    stall_en = 1'b0;
    settle();
    program_regs(MODE_LENGTH, 1'b1, MAX_LENGTH_RST);
    build_phase(MODE_LENGTH, 20);
    send_stream();
    settle();
    program_regs(MODE_DELIM, 1'b0, 31'd0);
    build_phase(MODE_DELIM, 20);
    send_stream();
  endtask

  // Result side: ready with random stall bursts while enabled.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.out_byte     = out_ch.out_byte;
      got.byte_valid   = out_ch.byte_valid;
      got.message_end  = out_ch.message_end;
      got.length_error = out_ch.length_error;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: byte=%02h valid=%0b end=%0b err=%0b",
                   got.out_byte, got.byte_valid, got.message_end, got.length_error);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          if (mismatch_count < 10)
            $display("mismatch: expected byte=%02h valid=%0b end=%0b err=%0b,",
                     want.out_byte, want.byte_valid, want.message_end, want.length_error,
                     " got byte=%02h valid=%0b end=%0b err=%0b",
                     got.out_byte, got.byte_valid, got.message_end, got.length_error);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_FRAMING_MODE;
    cfg_ch.data    <= 31'd0;
    p_mode         = MODE_PASS;
    p_max          = MAX_LENGTH_RST;
    hdr_cnt        = 0;
    hdr_val        = 32'd0;
    remaining      = 31'd0;
    in_payload     = 1'b0;
    held_cnt       = 0;
    mismatch_count = 0;
    bytes_sent     = 0;
    cycle_count    = 0;
    gaps_en        = 1'b0;
    stall_en       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_spare_mode();
    test_length_directed();
    test_delimiter_directed();
    test_random_phases();
    test_full_rate();

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
